// ----- rtl/hkm_pkg.sv -----
package hkm_pkg;

    localparam int MAX_LISTS  = 16;
    localparam int VALUE_BITS = 31;
    localparam int IDX_W      = $clog2(MAX_LISTS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int SRC_W      = 4;
    localparam int ID_W       = 4;
    localparam int LC_W       = 5;

    localparam int IN_TDATA_W  = ((ID_W + VALUE_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((VALUE_BITS + SRC_W + 7) / 8) * 8;

    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;
    localparam int REG_IDX_W = APB_AW - 2;

    localparam logic [REG_IDX_W-1:0] REG_LIST_COUNT = REG_IDX_W'(0);
    localparam logic [LC_W-1:0]      LC_RESET       = LC_W'(16);

    typedef struct packed {
        logic [VALUE_BITS-1:0] key;
        logic [SRC_W-1:0]      src;
    } entry_t;

    typedef struct packed {
        logic pick_right;
        logic keep_car;
        logic finish;
    } dec_t;

endpackage

// ----- rtl/hkm_ram.sv -----
module hkm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    output logic [WIDTH-1:0]         rd_data_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

// ----- rtl/hkm_cfg.sv -----
module hkm_cfg (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [hkm_pkg::APB_AW-1:0]   paddr,
    input  logic [hkm_pkg::APB_DW-1:0]   pwdata,
    output logic [hkm_pkg::APB_DW-1:0]   prdata,
    output logic                         pready,
    output logic [hkm_pkg::LC_W-1:0]     list_count
);

    logic [hkm_pkg::LC_W-1:0]      list_count_reg;
    logic [hkm_pkg::REG_IDX_W-1:0] reg_idx;
    logic                          wr_hit;

    assign reg_idx = paddr[hkm_pkg::APB_AW-1:2];
    assign pready  = 1'b1;
    assign wr_hit  = psel && penable && pwrite && pready &&
                     (reg_idx == hkm_pkg::REG_LIST_COUNT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            list_count_reg <= hkm_pkg::LC_RESET;
        end else if (wr_hit) begin
            list_count_reg <= pwdata[hkm_pkg::LC_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            hkm_pkg::REG_LIST_COUNT: prdata = hkm_pkg::APB_DW'(list_count_reg);
            default:                 prdata = '0;
        endcase
    end

    assign list_count = list_count_reg;

endmodule

// ----- rtl/hkm_cmp.sv -----
module hkm_cmp (
    input  hkm_pkg::entry_t car,
    input  hkm_pkg::entry_t left,
    input  hkm_pkg::entry_t right,
    input  logic            r_ok,
    input  logic            build,
    output hkm_pkg::dec_t   dec,
    output hkm_pkg::entry_t child
);

    logic pick_right;

    assign pick_right = r_ok && (right.key > left.key);
    assign child      = pick_right ? right : left;

    always_comb begin
        dec.pick_right = pick_right;
        if (build) begin
            // parent holds on equal keys
            dec.keep_car = !(child.key > car.key);
            dec.finish   = !(child.key > car.key);
        end else begin
            // child rises on equal keys
            dec.keep_car = car.key > child.key;
            dec.finish   = 1'b0;
        end
    end

endmodule

// ----- rtl/heap_kway_merge.sv -----
// Load item: stored in heap RAM; the last head starts a bottom-up build reading each parent
// (S_BLD_RD, S_BLD_LD) and sifts it down, an S_RD and S_CMP per level, one more S_RD where a
// sift reaches a leaf; then S_TOP_RD and S_TOP read and present the top.
// Merge item: sifted from root to leaf, an S_RD and S_CMP per level, then S_TOP_RD and S_TOP;
// the sift loop reads both children through the two read ports of the heap RAM each level.
// One item is worked on at a time; the output register holds a result until taken.
// Reset (aresetn low, synchronous): load phase, no lists loaded, list_count 16; heap RAM kept.
module heap_kway_merge (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [hkm_pkg::APB_AW-1:0]        paddr,
    input  logic [hkm_pkg::APB_DW-1:0]        pwdata,
    output logic [hkm_pkg::APB_DW-1:0]        prdata,
    output logic                              pready,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [hkm_pkg::IN_TDATA_W-1:0]    s_tdata,  // list_id, value
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [hkm_pkg::OUT_TDATA_W-1:0]   m_tdata,  // merged_value, source_list
    output logic                              m_tuser   // done_res
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_BLD_RD = 3'd1;
    localparam logic [2:0] S_BLD_LD = 3'd2;
    localparam logic [2:0] S_RD     = 3'd3;
    localparam logic [2:0] S_CMP    = 3'd4;
    localparam logic [2:0] S_TOP_RD = 3'd5;
    localparam logic [2:0] S_TOP    = 3'd6;

    localparam int IDX_W = hkm_pkg::IDX_W;
    localparam int CNT_W = hkm_pkg::CNT_W;

    logic [2:0]                       state_reg, state_next;
    logic [CNT_W-1:0]                 cnt_reg, cnt_next;
    logic                             merging_reg, merging_next;
    logic                             build_reg, build_next;
    logic [IDX_W-1:0]                 bp_reg, bp_next;
    logic [IDX_W-1:0]                 pos_reg, pos_next;
    hkm_pkg::entry_t                  car_reg, car_next;
    logic [hkm_pkg::SRC_W-1:0]        top_src_reg, top_src_next;
    logic                             m_valid_reg, m_valid_next;
    logic [hkm_pkg::VALUE_BITS-1:0]   m_value_reg;
    logic [hkm_pkg::SRC_W-1:0]        m_src_reg;
    logic                             m_done_reg;

    logic [hkm_pkg::LC_W-1:0]         list_count;
    logic [CNT_W-1:0]                 eff_cnt;
    logic [CNT_W-1:0]                 cnt_inc;
    logic [CNT_W-1:0]                 half_cnt;
    logic [hkm_pkg::VALUE_BITS-1:0]   in_value;
    logic [CNT_W-1:0]                 l_idx;
    logic [CNT_W-1:0]                 r_idx;
    logic                             l_ok;
    logic                             r_ok;
    logic [IDX_W-1:0]                 child_idx;
    logic                             wr_en;
    logic [IDX_W-1:0]                 wr_addr;
    hkm_pkg::entry_t                  wr_data;
    logic [IDX_W-1:0]                 rd_addr_a;
    hkm_pkg::entry_t                  rd_data_a;
    hkm_pkg::entry_t                  rd_data_b;
    hkm_pkg::dec_t                    dec;
    hkm_pkg::entry_t                  child;
    logic                             sift_done;
    logic                             out_load;
    logic                             s_accept;

    hkm_cfg u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .list_count (list_count)
    );

    hkm_ram #(
        .WIDTH ($bits(hkm_pkg::entry_t)),
        .DEPTH (hkm_pkg::MAX_LISTS)
    ) u_heap (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_data_a (rd_data_a),
        .rd_addr_b (r_idx[IDX_W-1:0]),
        .rd_data_b (rd_data_b)
    );

    hkm_cmp u_cmp (
        .car   (car_reg),
        .left  (rd_data_a),
        .right (rd_data_b),
        .r_ok  (r_ok),
        .build (build_reg),
        .dec   (dec),
        .child (child)
    );

    assign in_value = s_tdata[hkm_pkg::ID_W +: hkm_pkg::VALUE_BITS];
    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        if (list_count == '0) begin
            eff_cnt = CNT_W'(1);
        end else if (int'(list_count) > hkm_pkg::MAX_LISTS) begin
            eff_cnt = CNT_W'(hkm_pkg::MAX_LISTS);
        end else begin
            eff_cnt = CNT_W'(list_count);
        end
    end

    assign cnt_inc   = cnt_reg + CNT_W'(1);
    assign half_cnt  = cnt_inc >> 1;
    assign l_idx     = {pos_reg, 1'b1};
    assign r_idx     = l_idx + CNT_W'(1);
    assign l_ok      = l_idx < cnt_reg;
    assign r_ok      = r_idx < cnt_reg;
    assign child_idx = dec.pick_right ? r_idx[IDX_W-1:0] : l_idx[IDX_W-1:0];

    always_comb begin
        unique case (state_reg)
            S_BLD_RD: rd_addr_a = bp_reg;
            S_RD:     rd_addr_a = l_idx[IDX_W-1:0];
            default:  rd_addr_a = '0;
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        merging_next = merging_reg;
        build_next   = build_reg;
        bp_next      = bp_reg;
        pos_next     = pos_reg;
        car_next     = car_reg;
        top_src_next = top_src_reg;
        m_valid_next = m_valid_reg && !m_tready;
        out_load     = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = pos_reg;
        wr_data      = car_reg;
        sift_done    = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    if (!merging_reg) begin
                        wr_en    = 1'b1;
                        wr_addr  = cnt_reg[IDX_W-1:0];
                        wr_data  = '{key: in_value, src: cnt_reg[hkm_pkg::SRC_W-1:0]};
                        cnt_next = cnt_inc;
                        if (cnt_inc >= eff_cnt) begin
                            merging_next = 1'b1;
                            if (cnt_inc > CNT_W'(1)) begin
                                bp_next    = IDX_W'(half_cnt - CNT_W'(1));
                                state_next = S_BLD_RD;
                            end else begin
                                state_next = S_TOP_RD;
                            end
                        end
                    end else begin
                        car_next   = '{key: in_value, src: top_src_reg};
                        pos_next   = '0;
                        build_next = 1'b0;
                        state_next = S_RD;
                    end
                end
            end
            S_BLD_RD: begin
                state_next = S_BLD_LD;
            end
            S_BLD_LD: begin
                car_next   = rd_data_a;
                pos_next   = bp_reg;
                build_next = 1'b1;
                state_next = S_RD;
            end
            S_RD: begin
                if (!l_ok) begin
                    wr_en     = 1'b1;
                    sift_done = 1'b1;
                end else begin
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                wr_en   = 1'b1;
                wr_data = dec.keep_car ? car_reg : child;
                if (dec.finish) begin
                    sift_done = 1'b1;
                end else begin
                    pos_next = child_idx;
                    if (dec.keep_car) begin
                        car_next = child;
                    end
                    state_next = S_RD;
                end
            end
            S_TOP_RD: begin
                state_next = S_TOP;
            end
            S_TOP: begin
                if (!m_valid_reg || m_tready) begin
                    out_load     = 1'b1;
                    m_valid_next = 1'b1;
                    top_src_next = rd_data_a.src;
                    if (rd_data_a.key == '0) begin
                        merging_next = 1'b0;
                        cnt_next     = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (sift_done) begin
            if (build_reg && (bp_reg != '0)) begin
                bp_next    = bp_reg - IDX_W'(1);
                state_next = S_BLD_RD;
            end else begin
                state_next = S_TOP_RD;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            merging_reg <= 1'b0;
            build_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            merging_reg <= merging_next;
            build_reg   <= build_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        bp_reg      <= bp_next;
        pos_reg     <= pos_next;
        car_reg     <= car_next;
        top_src_reg <= top_src_next;
        if (out_load) begin
            m_value_reg <= rd_data_a.key;
            m_src_reg   <= (rd_data_a.key == '0) ? '0 : rd_data_a.src;
            m_done_reg  <= (rd_data_a.key == '0);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = hkm_pkg::OUT_TDATA_W'({m_src_reg, m_value_reg});
    assign m_tuser  = m_done_reg;

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(hkm_pkg::MAX_LISTS))
        else $error("loaded count above heap depth");

    a_merge_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (merging_reg && state_reg == S_IDLE) |-> cnt_reg != '0)
        else $error("merge phase with empty heap");

    a_cmp_in_heap: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CMP) |-> (l_idx < cnt_reg && CNT_W'(pos_reg) < cnt_reg))
        else $error("sift compare outside heap");

    a_done_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("done item carries data");

    a_busy_after_merge: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && merging_reg) |=> !s_tready)
        else $error("merge item did not start a sift");

endmodule
